[sv/plt_pkg.sv]
// Package for the positional list table.
// Holds sizes, request and status codes, and the request, result and cell control types.
`default_nettype none
package plt_pkg;

  localparam int CAPACITY = 16;
  localparam int DATA_W   = 32;
  localparam int IDX_W    = 4;
  localparam int CNT_W    = 5;

  typedef enum logic [1:0] {
    REQ_INSERT = 2'd0,
    REQ_DELETE = 2'd1,
    REQ_FIND   = 2'd2,
    REQ_READ   = 2'd3
  } req_kind_t;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_FULL     = 3'd1,
    ST_EMPTY    = 3'd2,
    ST_BADPOS   = 3'd3,
    ST_NOTFOUND = 3'd4
  } status_t;

  typedef struct packed {
    req_kind_t          req_type;
    logic [3:0]         position;
    logic signed [31:0] value;
  } plt_req_t;

  typedef struct packed {
    status_t            status;
    logic [3:0]         found_index;
    logic signed [31:0] read_value;
    logic [4:0]         entry_count;
  } plt_res_t;

  typedef struct packed {
    logic              ins_en;
    logic              del_en;
    logic [IDX_W-1:0]  pos;
    logic [CNT_W-1:0]  count;
    logic [DATA_W-1:0] value;
  } plt_ctrl_t;

endpackage
`default_nettype wire

[sv/plt_cell.sv]
// One storage cell of the positional list table.
// Depends on plt_pkg for the sizes and the shared control struct.
`default_nettype none
module plt_cell
  import plt_pkg::*;
(
  input  wire logic              clk,
  input  wire logic [IDX_W-1:0]  cell_idx,
  input  wire plt_ctrl_t         ctrl,
  input  wire logic [DATA_W-1:0] left_data,
  input  wire logic [DATA_W-1:0] right_data,
  output logic      [DATA_W-1:0] data,
  output logic                   match
);

  logic [DATA_W-1:0] data_r;
  logic [DATA_W-1:0] data_nxt;
  logic [CNT_W-1:0]  idx_ext;
  logic [CNT_W-1:0]  pos_ext;

  assign idx_ext = CNT_W'(cell_idx);
  assign pos_ext = CNT_W'(ctrl.pos);

  always_comb begin
    data_nxt = data_r;
    if (ctrl.ins_en) begin
      if (idx_ext == pos_ext) begin
        data_nxt = ctrl.value;
      end else if (idx_ext > pos_ext && idx_ext <= ctrl.count) begin
        data_nxt = left_data;
      end
    end else if (ctrl.del_en) begin
      if (idx_ext >= pos_ext && (idx_ext + CNT_W'(1)) < ctrl.count) begin
        data_nxt = right_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data  = data_r;
  assign match = (idx_ext < ctrl.count) && (data_r == ctrl.value);

endmodule
`default_nettype wire

[sv/positional_list_table.sv]
// A result is registered when its request is accepted and is valid in the next cycle.
// Throughput: one request per cycle; all cells shift and compare in parallel,
// and a new request is taken whenever the output register is empty or being taken.
// Reset: synchronous, active low; empties the list and the output register.
// Depends on plt_pkg and plt_cell.
`default_nettype none
module positional_list_table
  import plt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     in_valid,
  output logic          in_stall,
  input  wire plt_req_t in_req,
  output logic          out_valid,
  input  wire logic     out_stall,
  output plt_res_t      out_res
);

  logic [CNT_W-1:0]  count_r;
  logic [CNT_W-1:0]  count_nxt;
  logic              out_valid_r;
  logic              out_valid_nxt;
  plt_res_t          out_res_r;
  plt_res_t          out_res_nxt;
  plt_ctrl_t         ctrl;
  logic              accept;
  logic              ins_ok;
  logic              del_ok;
  logic [CNT_W-1:0]  pos_ext;
  logic [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0] match;
  logic              found;
  logic [IDX_W-1:0]  found_idx;

  assign in_stall = out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;
  assign pos_ext  = CNT_W'(in_req.position);

  assign ins_ok = (in_req.req_type == REQ_INSERT) && (count_r < CNT_W'(CAPACITY)) &&
                  (pos_ext <= count_r);
  assign del_ok = (in_req.req_type == REQ_DELETE) && (count_r != '0) &&
                  (pos_ext < count_r);

  assign ctrl.ins_en = accept && ins_ok;
  assign ctrl.del_en = accept && del_ok;
  assign ctrl.pos    = in_req.position;
  assign ctrl.count  = count_r;
  assign ctrl.value  = DATA_W'(in_req.value);

  for (genvar k = 0; k < CAPACITY; k++) begin : g_cell
    logic [DATA_W-1:0] left_d;
    logic [DATA_W-1:0] right_d;
    if (k == 0) begin : g_first
      assign left_d = ctrl.value;
    end else begin : g_mid_l
      assign left_d = cell_data[k-1];
    end
    if (k == CAPACITY - 1) begin : g_last
      assign right_d = cell_data[k];
    end else begin : g_mid_r
      assign right_d = cell_data[k+1];
    end
    plt_cell u_cell (
      .clk        (clk),
      .cell_idx   (IDX_W'(k)),
      .ctrl       (ctrl),
      .left_data  (left_d),
      .right_data (right_d),
      .data       (cell_data[k]),
      .match      (match[k])
    );
  end

  always_comb begin
    found_idx = '0;
    for (int k = CAPACITY - 1; k >= 0; k--) begin
      if (match[k]) begin
        found_idx = IDX_W'(k);
      end
    end
  end

  assign found = |match;

  always_comb begin
    count_nxt               = count_r;
    out_res_nxt.status      = ST_OK;
    out_res_nxt.found_index = '0;
    out_res_nxt.read_value  = '0;
    unique case (in_req.req_type)
      REQ_INSERT: begin
        if (count_r >= CNT_W'(CAPACITY)) begin
          out_res_nxt.status = ST_FULL;
        end else if (!ins_ok) begin
          out_res_nxt.status = ST_BADPOS;
        end else begin
          count_nxt = count_r + CNT_W'(1);
        end
      end
      REQ_DELETE: begin
        if (count_r == '0) begin
          out_res_nxt.status = ST_EMPTY;
        end else if (!del_ok) begin
          out_res_nxt.status = ST_BADPOS;
        end else begin
          count_nxt = count_r - CNT_W'(1);
        end
      end
      REQ_FIND: begin
        if (found) begin
          out_res_nxt.found_index = found_idx;
        end else begin
          out_res_nxt.status = ST_NOTFOUND;
        end
      end
      REQ_READ: begin
        if (pos_ext >= count_r) begin
          out_res_nxt.status = ST_BADPOS;
        end else begin
          out_res_nxt.read_value = 32'(cell_data[in_req.position]);
        end
      end
    endcase
    out_res_nxt.entry_count = count_nxt;
  end

  always_comb begin
    out_valid_nxt = out_valid_r && out_stall;
    if (accept) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      if (accept) begin
        count_r <= count_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_res_r <= out_res_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

endmodule
`default_nettype wire

[sv/plt_checker.sv]
// Port-level checks for the positional list table, bound to the top level.
// Depends on plt_pkg for the codes and the request and result types.
`default_nettype none
module plt_checker
  import plt_pkg::*;
(
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire plt_req_t in_req,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire plt_res_t out_res
);

  a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_res))
    else $error("Stalled result changed.");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> out_valid)
    else $error("Accepted request gave no result in the next cycle.");

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_res.entry_count <= 5'(CAPACITY))
    else $error("Entry count exceeds capacity.");

  a_full_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_res.status == ST_FULL |-> out_res.entry_count == 5'(CAPACITY))
    else $error("Full status reported with a list that is not full.");

  a_insert_count: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_req.req_type == REQ_INSERT |=>
      out_res.status != ST_OK || out_res.entry_count != '0)
    else $error("Successful insert left the list empty.");

endmodule

bind positional_list_table plt_checker u_plt_checker (.*);
`default_nettype wire
